// ===== hdl/hpdt_pkg.sv =====
// shared constants, codes and structs of the hpack dynamic table
`default_nettype none

package hpdt_pkg;

    localparam int MAX_TABLE_BYTES = 4096;
    localparam int SLOT_COUNT      = 128;
    localparam int PTR_W           = $clog2(SLOT_COUNT);
    localparam int CNT_W           = $clog2(SLOT_COUNT + 1);
    localparam int BYTES_W         = $clog2(MAX_TABLE_BYTES + 1);
    localparam int SLOT_W          = 32;
    localparam int ALU_W           = 17;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_RESIZE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_INDEX    = 2'd1,
        ST_BAD_CAPACITY = 2'd2,
        ST_TOO_LARGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] entry_handle;
        logic [15:0] entry_size;
        logic [7:0]  lookup_index;
        logic [15:0] new_capacity;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_handle;
        logic [15:0] found_size;
        logic [7:0]  evicted_count;
        logic [7:0]  entry_count;
        logic [12:0] table_bytes;
    } t_result;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             carry;
    } t_alu_rsp;

    typedef struct packed {
        logic              we;
        logic [PTR_W-1:0]  waddr;
        logic [SLOT_W-1:0] wdata;
        logic              re;
        logic [PTR_W-1:0]  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== hdl/hpdt_cmd_if.sv =====
// command channel of the hpack dynamic table
`default_nettype none

interface hpdt_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] entry_handle;
    logic [15:0] entry_size;
    logic [7:0]  lookup_index;
    logic [15:0] new_capacity;

    modport source (
        output valid, func, entry_handle, entry_size, lookup_index, new_capacity,
        input  ready
    );
    modport sink (
        input  valid, func, entry_handle, entry_size, lookup_index, new_capacity,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/hpdt_rsp_if.sv =====
// response channel of the hpack dynamic table
`default_nettype none

interface hpdt_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] found_handle;
    logic [15:0] found_size;
    logic [7:0]  evicted_count;
    logic [7:0]  entry_count;
    logic [12:0] table_bytes;

    modport source (
        output valid, status, found_handle, found_size, evicted_count, entry_count,
               table_bytes,
        input  ready
    );
    modport sink (
        input  valid, status, found_handle, found_size, evicted_count, entry_count,
               table_bytes,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/hpdt_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module hpdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/hpdt_alu.sv =====
// shared add / subtract unit with carry (borrow on subtract)
`default_nettype none

module hpdt_alu (
    input  wire hpdt_pkg::t_alu_req i_req,
    output hpdt_pkg::t_alu_rsp      o_rsp
);

    logic [hpdt_pkg::ALU_W:0] w_sum;

    always_comb begin
        if (i_req.sub) begin
            w_sum = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.res   = w_sum[hpdt_pkg::ALU_W-1:0];
        o_rsp.carry = w_sum[hpdt_pkg::ALU_W];
    end

endmodule

`default_nettype wire

// ===== hdl/hpdt_seq.sv =====
// sequencer and table state: ring pointers, entry count, byte total, capacity
`default_nettype none

module hpdt_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire hpdt_pkg::t_cmd                  i_cmd,
    input  wire logic                            i_out_free,
    output logic                                 o_idle,
    output logic                                 o_done,
    output hpdt_pkg::t_result                    o_result,
    output hpdt_pkg::t_alu_req                   o_alu_req,
    input  wire hpdt_pkg::t_alu_rsp              i_alu_rsp,
    output hpdt_pkg::t_ram_req                   o_ram_req,
    input  wire logic [hpdt_pkg::SLOT_W-1:0]     i_ram_rdata
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_ROOM  = 8'b0000_0100,
        S_EVAL  = 8'b0000_1000,
        S_DROP  = 8'b0001_0000,
        S_GROW  = 8'b0010_0000,
        S_LOOK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state                          r_state, n_state;
    hpdt_pkg::t_cmd                  r_cmd, n_cmd;
    logic [hpdt_pkg::PTR_W-1:0]      r_newest, n_newest;
    logic [hpdt_pkg::PTR_W-1:0]      r_oldest, n_oldest;
    logic [hpdt_pkg::CNT_W-1:0]      r_count, n_count;
    logic [hpdt_pkg::BYTES_W-1:0]    r_used, n_used;
    logic [hpdt_pkg::BYTES_W-1:0]    r_cap, n_cap;
    logic [hpdt_pkg::BYTES_W-1:0]    r_acc, n_acc;
    logic [hpdt_pkg::CNT_W-1:0]      r_evicted, n_evicted;
    logic [1:0]                      r_status, n_status;
    logic [15:0]                     r_found_handle, n_found_handle;
    logic [15:0]                     r_found_size, n_found_size;
    logic                            w_need;

    always_comb begin
        n_state        = r_state;
        n_cmd          = r_cmd;
        n_newest       = r_newest;
        n_oldest       = r_oldest;
        n_count        = r_count;
        n_used         = r_used;
        n_cap          = r_cap;
        n_acc          = r_acc;
        n_evicted      = r_evicted;
        n_status       = r_status;
        n_found_handle = r_found_handle;
        n_found_size   = r_found_size;
        o_alu_req      = '0;
        o_ram_req      = '0;
        o_done         = 1'b0;
        w_need         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_cmd          = i_cmd;
                    n_evicted      = '0;
                    n_status       = hpdt_pkg::ST_OK;
                    n_found_handle = '0;
                    n_found_size   = '0;
                    n_state        = S_CHECK;
                end
            end
            S_CHECK: begin
                o_alu_req.sub = 1'b1;
                unique case (r_cmd.func)
                    hpdt_pkg::FUNC_ADD: begin
                        o_alu_req.a = hpdt_pkg::ALU_W'(r_cap);
                        o_alu_req.b = hpdt_pkg::ALU_W'(r_cmd.entry_size);
                        if (i_alu_rsp.carry) begin
                            // entry larger than the capacity empties the table
                            n_evicted = r_count;
                            n_newest  = '0;
                            n_oldest  = '0;
                            n_count   = '0;
                            n_used    = '0;
                            n_status  = hpdt_pkg::ST_TOO_LARGE;
                            n_state   = S_DONE;
                        end else begin
                            n_state = S_ROOM;
                        end
                    end
                    hpdt_pkg::FUNC_LOOKUP: begin
                        o_alu_req.a = hpdt_pkg::ALU_W'(r_count);
                        o_alu_req.b = hpdt_pkg::ALU_W'(r_cmd.lookup_index);
                        if (i_alu_rsp.carry || r_cmd.lookup_index == '0) begin
                            n_status = hpdt_pkg::ST_BAD_INDEX;
                            n_state  = S_DONE;
                        end else begin
                            o_ram_req.re    = 1'b1;
                            o_ram_req.raddr = r_newest
                                              - hpdt_pkg::PTR_W'(r_cmd.lookup_index);
                            n_state         = S_LOOK;
                        end
                    end
                    hpdt_pkg::FUNC_RESIZE: begin
                        o_alu_req.a = hpdt_pkg::ALU_W'(hpdt_pkg::MAX_TABLE_BYTES);
                        o_alu_req.b = hpdt_pkg::ALU_W'(r_cmd.new_capacity);
                        if (i_alu_rsp.carry) begin
                            n_status = hpdt_pkg::ST_BAD_CAPACITY;
                            n_state  = S_DONE;
                        end else if (hpdt_pkg::BYTES_W'(r_cmd.new_capacity) == r_cap) begin
                            n_state = S_DONE;
                        end else begin
                            n_cap = hpdt_pkg::BYTES_W'(r_cmd.new_capacity);
                            if (r_cmd.new_capacity == '0) begin
                                n_evicted = r_count;
                                n_newest  = '0;
                                n_oldest  = '0;
                                n_count   = '0;
                                n_used    = '0;
                                n_state   = S_DONE;
                            end else begin
                                n_state = S_ROOM;
                            end
                        end
                    end
                    hpdt_pkg::FUNC_NONE: begin
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ROOM: begin
                // free room: capacity minus bytes in use
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = hpdt_pkg::ALU_W'(r_cap);
                o_alu_req.b   = hpdt_pkg::ALU_W'(r_used);
                if (r_cmd.func == hpdt_pkg::FUNC_RESIZE) begin
                    if (r_count != '0 && i_alu_rsp.carry) begin
                        o_ram_req.re    = 1'b1;
                        o_ram_req.raddr = r_oldest;
                        n_state         = S_DROP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_acc   = i_alu_rsp.res[hpdt_pkg::BYTES_W-1:0];
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = hpdt_pkg::ALU_W'(r_acc);
                o_alu_req.b   = hpdt_pkg::ALU_W'(r_cmd.entry_size);
                w_need = (r_count != '0) && (i_alu_rsp.carry
                         || r_count == hpdt_pkg::CNT_W'(hpdt_pkg::SLOT_COUNT));
                if (w_need) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_oldest;
                    n_state         = S_DROP;
                end else begin
                    o_ram_req.we    = 1'b1;
                    o_ram_req.waddr = r_newest;
                    o_ram_req.wdata = {r_cmd.entry_handle, r_cmd.entry_size};
                    n_newest        = r_newest + 1'b1;
                    n_count         = r_count + 1'b1;
                    n_state         = S_GROW;
                end
            end
            S_DROP: begin
                // oldest entry's size has arrived from the ring
                o_alu_req.sub = 1'b1;
                o_alu_req.a   = hpdt_pkg::ALU_W'(r_used);
                o_alu_req.b   = hpdt_pkg::ALU_W'(i_ram_rdata[15:0]);
                n_used    = i_alu_rsp.carry ? '0 : i_alu_rsp.res[hpdt_pkg::BYTES_W-1:0];
                n_oldest  = r_oldest + 1'b1;
                n_count   = r_count - 1'b1;
                n_evicted = r_evicted + 1'b1;
                n_state   = S_ROOM;
            end
            S_GROW: begin
                o_alu_req.sub = 1'b0;
                o_alu_req.a   = hpdt_pkg::ALU_W'(r_used);
                o_alu_req.b   = hpdt_pkg::ALU_W'(r_cmd.entry_size);
                n_used  = i_alu_rsp.res[hpdt_pkg::BYTES_W-1:0];
                n_state = S_DONE;
            end
            S_LOOK: begin
                n_found_handle = i_ram_rdata[31:16];
                n_found_size   = i_ram_rdata[15:0];
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_newest <= '0;
            r_oldest <= '0;
            r_count  <= '0;
            r_used   <= '0;
            r_cap    <= hpdt_pkg::BYTES_W'(hpdt_pkg::MAX_TABLE_BYTES);
        end else begin
            r_state  <= n_state;
            r_newest <= n_newest;
            r_oldest <= n_oldest;
            r_count  <= n_count;
            r_used   <= n_used;
            r_cap    <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_acc          <= n_acc;
        r_evicted      <= n_evicted;
        r_status       <= n_status;
        r_found_handle <= n_found_handle;
        r_found_size   <= n_found_size;
    end

    assign o_idle                 = (r_state == S_IDLE);
    assign o_result.status        = r_status;
    assign o_result.found_handle  = r_found_handle;
    assign o_result.found_size    = r_found_size;
    assign o_result.evicted_count = 8'(r_evicted);
    assign o_result.entry_count   = 8'(r_count);
    assign o_result.table_bytes   = 13'(r_used);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hpdt_pkg::CNT_W'(hpdt_pkg::SLOT_COUNT))
        else $error("entry count beyond ring depth");

    a_ring_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hpdt_pkg::PTR_W'(r_oldest + hpdt_pkg::PTR_W'(r_count)) == r_newest)
        else $error("ring pointers disagree with entry count");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_used == '0)
        else $error("empty table still holds bytes");

    a_fits_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_used <= r_cap)
        else $error("byte total above capacity between operations");

endmodule

`default_nettype wire

// ===== hdl/hpack_dynamic_table.sv =====
// hpack dynamic table top level: ring memory, shared unit, sequencer, output stage
//
// usage:
//   i_cmd carries one operation per word: add (handle and size), lookup
//   (index 1 is the newest entry) or resize (new capacity in bytes).
//   o_rsp returns exactly one word per operation with status, the found
//   handle and size, the number of evicted entries, the entry count and
//   the byte total after the operation.
//   a valid lookup reads the ring once. a resize that is rejected, unchanged
//   or a clear touches no ring slot, else it evicts the oldest entries one
//   by one (ring read, subtract) until the bytes fit. an add of an entry
//   too large for the capacity empties the table, else it evicts one by
//   one (ring read, subtract, room check), then writes the entry and adds
//   its size. an unused code only returns a result. the sequencer steps
//   through the single add/subtract unit and the single ring read port.
//   i_cmd.ready is high only while the sequencer is idle, so the next
//   word is taken in the cycle after the last result enters the output register.
//   a stalled receiver holds the result in the output register; the block
//   accepts one more word meanwhile, then holds i_cmd.ready low until the
//   output register frees.
//   reset empties the table and sets the capacity to the maximum; the ring
//   memory itself is not cleared, since only occupied slots are ever read.
`default_nettype none

module hpack_dynamic_table (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hpdt_cmd_if.sink   i_cmd,
    hpdt_rsp_if.source o_rsp
);

    hpdt_pkg::t_cmd                  w_cmd;
    hpdt_pkg::t_result               w_result;
    hpdt_pkg::t_alu_req              w_alu_req;
    hpdt_pkg::t_alu_rsp              w_alu_rsp;
    hpdt_pkg::t_ram_req              w_ram_req;
    logic [hpdt_pkg::SLOT_W-1:0]     w_ram_rdata;
    logic                            w_idle;
    logic                            w_done;
    logic                            w_out_free;
    logic                            r_out_valid;
    hpdt_pkg::t_result               r_out;

    assign w_cmd.func         = i_cmd.func;
    assign w_cmd.entry_handle = i_cmd.entry_handle;
    assign w_cmd.entry_size   = i_cmd.entry_size;
    assign w_cmd.lookup_index = i_cmd.lookup_index;
    assign w_cmd.new_capacity = i_cmd.new_capacity;

    assign i_cmd.ready = w_idle;
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    hpdt_ram #(
        .WIDTH (hpdt_pkg::SLOT_W),
        .DEPTH (hpdt_pkg::SLOT_COUNT)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_waddr (w_ram_req.waddr),
        .i_wdata (w_ram_req.wdata),
        .i_re    (w_ram_req.re),
        .i_raddr (w_ram_req.raddr),
        .o_rdata (w_ram_rdata)
    );

    hpdt_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    hpdt_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.valid && w_idle),
        .i_cmd       (w_cmd),
        .i_out_free  (w_out_free),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_result    (w_result),
        .o_alu_req   (w_alu_req),
        .i_alu_rsp   (w_alu_rsp),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata)
    );

    // output register parts the sequencer from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_result;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.found_handle  = r_out.found_handle;
    assign o_rsp.found_size    = r_out.found_size;
    assign o_rsp.evicted_count = r_out.evicted_count;
    assign o_rsp.entry_count   = r_out.entry_count;
    assign o_rsp.table_bytes   = r_out.table_bytes;

endmodule

`default_nettype wire
